// ===== hw/rtl/date_to_epoch_seconds_core_defines.svh =====
// Assertion macros used by the checker file of the core.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DATE_TO_EPOCH_SECONDS_CORE_DEFINES_SVH
`define DATE_TO_EPOCH_SECONDS_CORE_DEFINES_SVH

// Plain property, sampled on the rising clock edge, off while reset is low.
`define D2E_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define D2E_ASSERT_NEXT(label, ante, cons, msg) \
    `D2E_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/d2e_pkg.sv =====
`default_nettype none

package d2e_pkg;

    localparam int YEAR_W    = 12;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int ZONE_W    = 17;
    localparam int EPOCH_W   = 33;

    // Day count is signed two's complement; time of day is unsigned.
    localparam int DAYS_W    = 22;
    localparam int HMS_W     = 17;

    localparam int EPOCH_YEAR         = 1970;
    // Leap years in 1..1969.
    localparam int LEAPS_BEFORE_EPOCH = 477;
    localparam int DAYS_PER_YEAR      = 365;
    localparam int SECS_PER_DAY       = 86400;
    localparam int SECS_PER_HOUR      = 3600;
    localparam int SECS_PER_MINUTE    = 60;
    localparam int ZONE_RESET         = 28800;

    // floor(n / 100) == (n * DIV100_MUL) >> DIV100_SHIFT for n below 43690.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;

    localparam int LAST_MONTH_IDX = 12;

    typedef logic signed [ZONE_W-1:0]  t_zone;
    typedef logic signed [EPOCH_W-1:0] t_epoch;

    typedef struct packed {
        logic s1;
        logic s2;
    } t_stage_en;

    // Days before the start of month index+1 in a common year.
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] idx);
        logic [8:0] days;
        case (idx)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            4'd11:   days = 9'd334;
            default: days = 9'd365;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/d2e_if.sv =====
`default_nettype none

interface d2e_in_if;
    logic                               valid;
    logic                               ready;
    logic [d2e_pkg::YEAR_W-1:0]         year;
    logic [d2e_pkg::MONTH_W-1:0]        month;
    logic [d2e_pkg::DAY_W-1:0]          day;
    logic [d2e_pkg::HOUR_W-1:0]         hour;
    logic [d2e_pkg::MINUTE_W-1:0]       minute;
    logic [d2e_pkg::SECOND_W-1:0]       second;

    modport source (output valid, year, month, day, hour, minute, second, input ready);
    modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface d2e_out_if;
    logic                  valid;
    logic                  ready;
    d2e_pkg::t_epoch       epoch_seconds;

    modport source (output valid, epoch_seconds, input ready);
    modport sink   (input valid, epoch_seconds, output ready);
endinterface

interface d2e_cfg_if;
    logic                  valid;
    logic                  ready;
    d2e_pkg::t_zone        zone_offset_seconds;

    modport source (output valid, zone_offset_seconds, input ready);
    modport sink   (input valid, zone_offset_seconds, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/d2e_days.sv =====
`default_nettype none

// Stages 1 and 2: calendar date to a signed day count, and time of day to seconds.
module d2e_days (
    input  wire                               i_clk,
    input  wire d2e_pkg::t_stage_en           i_en,
    input  wire [d2e_pkg::YEAR_W-1:0]         i_year,
    input  wire [d2e_pkg::MONTH_W-1:0]        i_month,
    input  wire [d2e_pkg::DAY_W-1:0]          i_day,
    input  wire [d2e_pkg::HOUR_W-1:0]         i_hour,
    input  wire [d2e_pkg::MINUTE_W-1:0]       i_minute,
    input  wire [d2e_pkg::SECOND_W-1:0]       i_second,
    output logic [d2e_pkg::DAYS_W-1:0]        o_days,
    output logic [d2e_pkg::HMS_W-1:0]         o_hms
);

    localparam int YW = d2e_pkg::YEAR_W;
    localparam int MW = d2e_pkg::MONTH_W;
    localparam int DW = d2e_pkg::DAYS_W;
    localparam int HW = d2e_pkg::HMS_W;

    // Stage 1 combinational.
    logic [YW-1:0] n_ym1;
    logic [24:0]   n_mul_y;
    logic [24:0]   n_mul_ym1;
    logic [22:0]   n_mul_q4;
    logic [MW-1:0] n_midx;
    logic [HW-1:0] n_hms;

    // Stage 1 registers.
    logic [YW-1:0] r_year;
    logic [5:0]    r_q100_y;
    logic [5:0]    r_q100_ym1;
    logic [9:0]    r_q4_ym1;
    logic [3:0]    r_q400_ym1;
    logic [MW-1:0] r_midx;
    logic [4:0]    r_day;
    logic [HW-1:0] r_hms;

    // Stage 2 combinational.
    logic [YW-1:0] n_hund;
    logic [YW-1:0] n_rem100;
    logic          n_leap;
    logic [10:0]   n_leaps;
    logic [20:0]   n_span;
    logic [DW-1:0] n_year_days;
    logic [DW-1:0] n_days;

    logic [DW-1:0] r_days;
    logic [HW-1:0] r_hms2;

    always_comb begin
        n_ym1     = i_year - YW'(1);
        n_mul_y   = 25'(i_year) * 25'(d2e_pkg::DIV100_MUL);
        n_mul_ym1 = 25'(n_ym1) * 25'(d2e_pkg::DIV100_MUL);
        // floor(n / 400) is floor(floor(n / 4) / 100).
        n_mul_q4  = 23'(n_ym1[YW-1:2]) * 23'(d2e_pkg::DIV100_MUL);

        if (i_month == '0) begin
            n_midx = '0;
        end else if (i_month - MW'(1) > MW'(d2e_pkg::LAST_MONTH_IDX)) begin
            n_midx = MW'(d2e_pkg::LAST_MONTH_IDX);
        end else begin
            n_midx = i_month - MW'(1);
        end

        n_hms = HW'(i_hour) * HW'(d2e_pkg::SECS_PER_HOUR)
              + HW'(i_minute) * HW'(d2e_pkg::SECS_PER_MINUTE)
              + HW'(i_second);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_year     <= i_year;
            r_q100_y   <= n_mul_y[24:d2e_pkg::DIV100_SHIFT];
            r_q100_ym1 <= n_mul_ym1[24:d2e_pkg::DIV100_SHIFT];
            r_q4_ym1   <= n_ym1[YW-1:2];
            r_q400_ym1 <= n_mul_q4[22:d2e_pkg::DIV100_SHIFT];
            r_midx     <= n_midx;
            r_day      <= i_day;
            r_hms      <= n_hms;
        end
    end

    always_comb begin
        n_hund   = YW'(r_q100_y) * YW'(100);
        n_rem100 = r_year - n_hund;
        // A year divisible by 400 is a century whose hundreds count is a multiple of 4.
        n_leap   = (r_year[1:0] == 2'b00) && ((n_rem100 != '0) || (r_q100_y[1:0] == 2'b00));
        n_leaps  = 11'(r_q4_ym1) + 11'(r_q400_ym1) - 11'(r_q100_ym1);

        n_span   = 21'(r_year - YW'(d2e_pkg::EPOCH_YEAR)) * 21'(d2e_pkg::DAYS_PER_YEAR);
        if (r_year > YW'(d2e_pkg::EPOCH_YEAR)) begin
            n_year_days = DW'(n_span) + DW'(n_leaps) - DW'(d2e_pkg::LEAPS_BEFORE_EPOCH);
        end else begin
            n_year_days = '0;
        end

        n_days = n_year_days
               + DW'(d2e_pkg::month_start(r_midx))
               + DW'(n_leap && (r_midx >= MW'(2)))
               + DW'(r_day)
               - DW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_days <= n_days;
            r_hms2 <= r_hms;
        end
    end

    assign o_days = r_days;
    assign o_hms  = r_hms2;

endmodule

`default_nettype wire

// ===== hw/rtl/date_to_epoch_seconds_core.sv =====
`default_nettype none

// Channel   Direction  Payload
// i_req     in         year, month, day, hour, minute, second
// o_rsp     out        epoch_seconds (signed, wraps modulo 2^33)
// i_cfg     in         zone_offset_seconds (signed), always ready
//
// One transaction per cycle in each direction while the output is not stalled.
// Four register stages: leap divisions, day count, day-to-seconds multiply, zone subtract.
// The 22 x 18 bit signed multiply of the third stage sets the clock period.
// Reset empties the pipeline and sets the zone offset to +28800 seconds.
// A stalled output holds its result; each stage accepts whenever its successor moves.
module date_to_epoch_seconds_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    d2e_in_if.sink     i_req,
    d2e_out_if.source  o_rsp,
    d2e_cfg_if.sink    i_cfg
);

    localparam int DW = d2e_pkg::DAYS_W;
    localparam int HW = d2e_pkg::HMS_W;
    localparam int EW = d2e_pkg::EPOCH_W;
    localparam int ZW = d2e_pkg::ZONE_W;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    d2e_pkg::t_stage_en w_en;
    d2e_pkg::t_zone     r_zone;

    logic [DW-1:0]         w_days;
    logic [HW-1:0]         w_hms;
    logic signed [39:0]    w_prod;
    logic [EW-1:0]         r_prod;
    logic [HW-1:0]         r_hms;
    logic [EW-1:0]         n_epoch;
    logic [EW-1:0]         r_epoch;

    assign w_rdy4 = !r_v4 || o_rsp.ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_en.s1 = w_rdy1;
    assign w_en.s2 = w_rdy2;

    assign i_req.ready = w_rdy1;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_zone <= ZW'(d2e_pkg::ZONE_RESET);
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_req.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (i_cfg.valid) begin
                r_zone <= i_cfg.zone_offset_seconds;
            end
        end
    end

    d2e_days u_days (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_year   (i_req.year),
        .i_month  (i_req.month),
        .i_day    (i_req.day),
        .i_hour   (i_req.hour),
        .i_minute (i_req.minute),
        .i_second (i_req.second),
        .o_days   (w_days),
        .o_hms    (w_hms)
    );

    assign w_prod = $signed(w_days) * $signed(18'(d2e_pkg::SECS_PER_DAY));

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_prod <= w_prod[EW-1:0];
            r_hms  <= w_hms;
        end
    end

    assign n_epoch = r_prod + EW'(r_hms) - {{(EW-ZW){r_zone[ZW-1]}}, r_zone};

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_epoch <= n_epoch;
        end
    end

    assign o_rsp.valid         = r_v4;
    assign o_rsp.epoch_seconds = r_epoch;

endmodule

`default_nettype wire

// ===== hw/rtl/d2e_checker.sv =====
`default_nettype none

`include "date_to_epoch_seconds_core_defines.svh"

module d2e_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready
);

    logic [2:0] r_inflight;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // Transactions taken in but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(w_in_acc) - 3'(w_out_acc);
        end
    end

    `D2E_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `D2E_ASSERT(a_ready_chain, i_out_ready |-> i_in_ready, "input stalled while output drains")
    `D2E_ASSERT(a_no_invent, i_out_valid |-> (r_inflight != 3'd0), "result without a pending input")
    `D2E_ASSERT(a_depth, r_inflight <= 3'd4, "more transactions in flight than pipeline stages")

endmodule

bind date_to_epoch_seconds_core d2e_checker u_d2e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import d2e_pkg::*;

    localparam int CLK_HALF          = 10;
    localparam int RESET_CYCLES      = 12;
    localparam int PHASES            = 9;
    localparam int FIXED_ZONES       = 7;
    localparam int RANDOM_PER_PHASE  = 92;
    localparam int LONG_HOLD_CYCLES  = 100;
    localparam int LONG_HOLD_AFTER   = 250;
    localparam int SETTLE_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT    = 2000;

    // Zone settings for the random phases; the last phases draw a random offset.
    localparam int ZONE_SETTINGS [0:FIXED_ZONES-1] =
        '{-50400, 50400, 0, -65536, 65535, -1, 28800};

    // Days before the start of month index+1 in a common year.
    localparam longint MONTH_START_DAYS [0:12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } date_item_t;

    typedef struct packed {
        date_item_t date;
        logic       known;
        t_epoch     want;
    } date_row_t;

    // Rows marked known carry the answer for the reset offset of +28800 seconds.
    date_row_t directed_rows [0:16] = '{
        '{'{12'd1970, 4'd1,  5'd1,  5'd8,  6'd0,  6'd0},  1'b1, 33'sd0},
        '{'{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, -33'sd28800},
        '{'{12'd0,    4'd0,  5'd0,  5'd0,  6'd0,  6'd0},  1'b1, -33'sd115200},
        '{'{12'd1970, 4'd0,  5'd1,  5'd8,  6'd0,  6'd0},  1'b1, 33'sd0},
        '{'{12'd1970, 4'd13, 5'd1,  5'd8,  6'd0,  6'd0},  1'b1, 33'sd31536000},
        '{'{12'd1900, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, 33'sd5068800},
        '{'{12'd1968, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, 33'sd5155200},
        '{'{12'd2000, 4'd1,  5'd1,  5'd8,  6'd0,  6'd0},  1'b1, 33'sd946684800},
        '{'{12'd2038, 4'd1,  5'd19, 5'd11, 6'd14, 6'd8},  1'b1, 33'sd2147483648},
        '{'{12'd1971, 4'd1,  5'd1,  5'd8,  6'd0,  6'd0},  1'b1, 33'sd31536000},
        '{'{12'd2000, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, 33'sd0},
        '{'{12'd2100, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, 33'sd0},
        '{'{12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd60}, 1'b0, 33'sd0},
        '{'{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63}, 1'b0, 33'sd0},
        '{'{12'd1970, 4'd1,  5'd1,  5'd31, 6'd63, 6'd63}, 1'b0, 33'sd0},
        '{'{12'd2024, 4'd2,  5'd29, 5'd12, 6'd0,  6'd0},  1'b0, 33'sd0},
        '{'{12'd1972, 4'd12, 5'd31, 5'd0,  6'd0,  6'd0},  1'b0, 33'sd0}
    };

    logic i_clk;
    logic i_rst_n;

    d2e_in_if  req_if ();
    d2e_out_if rsp_if ();
    d2e_cfg_if cfg_if ();

    date_to_epoch_seconds_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    t_epoch expected_epochs [$];
    t_epoch oldest_epoch;
    t_zone  zone_model;
    int     mismatch_count;
    int     results_seen;
    int     idle_cycles;
    int     burst_left;
    bit     long_hold_active;
    bit     long_hold_done;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic bit is_leap_year(input longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Leap years in 1..n, n not negative.
    function automatic longint leap_years_through(input longint n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic t_epoch epoch_from_date(input date_item_t d, input t_zone zone);
        longint yr;
        longint month_idx;
        longint days;
        longint total;
        yr = longint'(d.year);
        days = 0;
        // Years before the epoch count no whole years.
        if (yr > EPOCH_YEAR) begin
            days = (yr - EPOCH_YEAR) * DAYS_PER_YEAR
                 + leap_years_through(yr - 1) - leap_years_through(EPOCH_YEAR - 1);
        end
        month_idx = (d.month >= 1) ? longint'(d.month) - 1 : 0;
        if (month_idx > 12) begin
            month_idx = 12;
        end
        days += MONTH_START_DAYS[month_idx];
        if (month_idx >= 2 && is_leap_year(yr)) begin
            days += 1;
        end
        days += longint'(d.day) - 1;
        total = days * SECS_PER_DAY + longint'(d.hour) * SECS_PER_HOUR
              + longint'(d.minute) * SECS_PER_MINUTE + longint'(d.second)
              - longint'(zone);
        return total[EPOCH_W-1:0];
    endfunction

    function automatic date_item_t random_date();
        date_item_t d;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            d.month  = MONTH_W'($urandom_range(1, 12));
            d.year   = YEAR_W'($urandom_range(1970, 2099));
            d.day    = DAY_W'($urandom_range(1, 31));
            d.hour   = HOUR_W'($urandom_range(0, 23));
            d.minute = MINUTE_W'($urandom_range(0, 59));
            d.second = SECOND_W'($urandom_range(0, 60));
        end else if (pick < 85) begin
            // Calendar corners: century years, epoch edges, odd months and days.
            case ($urandom_range(0, 10))
                0:       d.year = YEAR_W'(0);
                1:       d.year = YEAR_W'(1900);
                2:       d.year = YEAR_W'(1968);
                3:       d.year = YEAR_W'(1969);
                4:       d.year = YEAR_W'(1970);
                5:       d.year = YEAR_W'(1971);
                6:       d.year = YEAR_W'(2000);
                7:       d.year = YEAR_W'(2038);
                8:       d.year = YEAR_W'(2099);
                9:       d.year = YEAR_W'(2100);
                default: d.year = YEAR_W'(4095);
            endcase
            case ($urandom_range(0, 7))
                0:       d.month = MONTH_W'(0);
                1:       d.month = MONTH_W'(1);
                2:       d.month = MONTH_W'(2);
                3:       d.month = MONTH_W'(3);
                4:       d.month = MONTH_W'(11);
                5:       d.month = MONTH_W'(12);
                6:       d.month = MONTH_W'(13);
                default: d.month = MONTH_W'(15);
            endcase
            case ($urandom_range(0, 5))
                0:       d.day = DAY_W'(0);
                1:       d.day = DAY_W'(1);
                2:       d.day = DAY_W'(28);
                3:       d.day = DAY_W'(29);
                4:       d.day = DAY_W'(30);
                default: d.day = DAY_W'(31);
            endcase
            d.hour   = ($urandom_range(0, 1) == 0) ? HOUR_W'(23) : HOUR_W'($urandom);
            d.minute = ($urandom_range(0, 1) == 0) ? MINUTE_W'(59) : MINUTE_W'($urandom);
            d.second = ($urandom_range(0, 1) == 0) ? SECOND_W'(60) : SECOND_W'($urandom);
        end else begin
            d = date_item_t'($urandom);
            d.year = YEAR_W'($urandom);
        end
        return d;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Offers one date; the sender works in bursts with random gaps between them.
    task automatic send_date(input date_item_t d, input logic known, input t_epoch want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (long_hold_active) begin
                gap = 0;
            end
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        req_if.valid  <= 1'b1;
        req_if.year   <= d.year;
        req_if.month  <= d.month;
        req_if.day    <= d.day;
        req_if.hour   <= d.hour;
        req_if.minute <= d.minute;
        req_if.second <= d.second;
        do @(posedge i_clk); while (!req_if.ready);
        expected_epochs.push_back(known ? want : epoch_from_date(d, zone_model));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_epochs.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_zone(input t_zone zone);
        cfg_if.valid               <= 1'b1;
        cfg_if.zone_offset_seconds <= zone;
        do @(posedge i_clk); while (!cfg_if.ready);
        zone_model = zone;
        cfg_if.valid <= 1'b0;
    endtask

    // Receiver: cycles through stall modes, plus one long hold-off to back up the pipeline.
    initial begin
        int rsp_cycle;
        int rsp_mode;
        rsp_cycle = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_cycle++;
            rsp_mode = (rsp_cycle / 64) % 4;
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER && req_if.valid) begin
                long_hold_active = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_active = 1'b0;
                long_hold_done = 1'b1;
                rsp_if.ready <= 1'b1;
            end else begin
                case (rsp_mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_if.ready <= (rsp_cycle % 4 != 3);
                    default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_epochs.size() == 0) begin
                report_mismatch($sformatf("unexpected result transaction, epoch_seconds=%0d",
                    rsp_if.epoch_seconds));
            end else begin
                oldest_epoch = expected_epochs.pop_front();
                if (rsp_if.epoch_seconds !== oldest_epoch) begin
                    report_mismatch($sformatf("epoch_seconds got %0d, want %0d",
                        rsp_if.epoch_seconds, oldest_epoch));
                end
            end
        end
    end

    // Ends the run when no transaction of any kind completes for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_zone zone;
        mismatch_count   = 0;
        results_seen     = 0;
        burst_left       = 0;
        long_hold_active = 1'b0;
        long_hold_done   = 1'b0;
        idle_cycles      = 0;
        zone_model       = t_zone'(ZONE_RESET);
        i_rst_n                    <= 1'b0;
        req_if.valid               <= 1'b0;
        req_if.year                <= '0;
        req_if.month               <= '0;
        req_if.day                 <= '0;
        req_if.hour                <= '0;
        req_if.minute              <= '0;
        req_if.second              <= '0;
        cfg_if.valid               <= 1'b0;
        cfg_if.zone_offset_seconds <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < $size(directed_rows); i++) begin
            send_date(directed_rows[i].date, directed_rows[i].known, directed_rows[i].want);
        end
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p < FIXED_ZONES) begin
                zone = t_zone'(ZONE_SETTINGS[p]);
            end else begin
                zone = t_zone'($urandom_range(0, 131071));
            end
            write_zone(zone);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_date(random_date(), 1'b0, '0);
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_epochs.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
